>>> design/zrle_pkg.sv
`timescale 1ns / 1ps
package zrle_pkg;

    // run kinds
    localparam logic [1:0] KIND_IDLE = 2'd0;
    localparam logic [1:0] KIND_ZERO = 2'd1;
    localparam logic [1:0] KIND_LIT  = 2'd2;

    // run limits and control byte flags
    localparam logic [5:0] RUN_MAX     = 6'h3f;
    localparam logic [5:0] MERGED_MAX  = 6'h0f;
    localparam logic [5:0] SHORT_ZERO  = 6'd8;
    localparam logic [7:0] MERGED_FLAG = 8'h80;
    localparam logic [7:0] ZERO_FLAG   = 8'h40;

    // literal buffer: holds an open run plus runs waiting in the back end
    localparam int LIT_AW    = 6;
    localparam int LIT_DEPTH = 1 << LIT_AW;
    localparam logic [LIT_AW:0] LIT_SLOTS = (LIT_AW + 1)'(LIT_DEPTH);

    // command queue between front and back
    localparam int CMDQ_AW    = 2;
    localparam int CMDQ_DEPTH = 1 << CMDQ_AW;
    localparam logic [CMDQ_AW:0] CMDQ_ROOM2 = (CMDQ_AW + 1)'(CMDQ_DEPTH - 2);

    // output queue in the back end
    localparam int OUTQ_AW    = 2;
    localparam int OUTQ_DEPTH = 1 << OUTQ_AW;
    localparam logic [OUTQ_AW:0] OUTQ_SLOTS = (OUTQ_AW + 1)'(OUTQ_DEPTH);

    // one closed run: its control byte and how many literals follow it
    typedef struct packed {
        logic [7:0] ctrl;
        logic [5:0] lit_cnt;
        logic       last;
        logic       blk_end;
    } cmd_t;

    // up to two commands pushed per accepted request, first one in order first
    typedef struct packed {
        logic [1:0] n;
        cmd_t       first;
        cmd_t       second;
    } cmd_push_t;

    typedef struct packed {
        logic [7:0] code;
        logic       is_ctrl;
        logic       last;
        logic       blk_end;
    } out_item_t;

    function automatic logic [7:0] lit_ctrl(input logic [2:0] held, input logic [5:0] cnt);
        if (held != 3'd0) begin
            lit_ctrl = MERGED_FLAG | {1'b0, held, 4'b0000} | {4'b0000, cnt[3:0]};
        end else begin
            lit_ctrl = {2'b00, cnt};
        end
    endfunction

endpackage

>>> design/zrle_lit_buf.sv
`timescale 1ns / 1ps
module zrle_lit_buf
    import zrle_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       wr_en,
    input  logic [7:0] wr_data,
    input  logic       rd_en,
    output logic [7:0] rd_data,
    output logic       has_room
);

    logic [7:0]      mem [LIT_DEPTH];
    logic [7:0]      rd_data_reg;
    logic [LIT_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [LIT_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LIT_AW:0]   cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_ptr_reg] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg + LIT_AW'(wr_en);
        rd_ptr_next = rd_ptr_reg + LIT_AW'(rd_en);
        cnt_next    = cnt_reg + (LIT_AW + 1)'(wr_en) - (LIT_AW + 1)'(rd_en);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    assign rd_data  = rd_data_reg;
    assign has_room = (cnt_reg != LIT_SLOTS);

endmodule

>>> design/zrle_cmdq.sv
`timescale 1ns / 1ps
module zrle_cmdq
    import zrle_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  cmd_push_t push,
    output logic      room2,
    output logic      head_valid,
    output cmd_t      head,
    input  logic      pop
);

    cmd_t               q_reg [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_AW:0]   cnt_reg, cnt_next;
    logic [CMDQ_AW-1:0] wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + CMDQ_AW'(1);

    always_ff @(posedge aclk) begin
        if (push.n != 2'd0) begin
            q_reg[wr_ptr_reg] <= push.first;
        end
        if (push.n == 2'd2) begin
            q_reg[wr_ptr_plus1] <= push.second;
        end
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg + CMDQ_AW'(push.n);
        rd_ptr_next = rd_ptr_reg + CMDQ_AW'(pop);
        cnt_next    = cnt_reg + (CMDQ_AW + 1)'(push.n) - (CMDQ_AW + 1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    assign room2      = (cnt_reg <= CMDQ_ROOM2);
    assign head_valid = (cnt_reg != '0);
    assign head       = q_reg[rd_ptr_reg];

endmodule

>>> design/zrle_front.sv
`timescale 1ns / 1ps
module zrle_front
    import zrle_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       final_byte,
    input  logic       cmdq_room2,
    input  logic       lit_room,
    output logic       lit_we,
    output logic [7:0] lit_wdata,
    output cmd_push_t  push
);

    logic [1:0] kind_reg, kind_next;
    logic [5:0] count_reg, count_next;
    logic [2:0] held_reg, held_next;

    logic       acc;
    logic [1:0] kind_v;
    logic [5:0] cnt_v;
    logic [2:0] held_v;
    logic       a_v, b_v;
    cmd_t       cmd_a, cmd_b;
    logic [5:0] nc, c, lim;
    logic [2:0] h;

    assign in_ready  = cmdq_room2 && lit_room;
    assign acc       = in_valid && in_ready;
    assign lit_wdata = data_byte;

    // unused kind code reads as idle
    always_comb begin
        if (kind_reg == KIND_ZERO || kind_reg == KIND_LIT) begin
            kind_v = kind_reg;
            cnt_v  = count_reg;
            held_v = held_reg;
        end else begin
            kind_v = KIND_IDLE;
            cnt_v  = '0;
            held_v = '0;
        end
    end

    // A closes the run already open, B closes the run this byte belongs to
    always_comb begin
        a_v        = 1'b0;
        b_v        = 1'b0;
        cmd_a      = '0;
        cmd_b      = '0;
        lit_we     = 1'b0;
        kind_next  = kind_v;
        count_next = cnt_v;
        held_next  = held_v;
        c          = cnt_v;
        h          = held_v;
        nc         = '0;
        lim        = RUN_MAX;

        if (data_byte == 8'd0) begin
            if (kind_v == KIND_LIT) begin
                a_v           = 1'b1;
                cmd_a.ctrl    = lit_ctrl(held_v, cnt_v);
                cmd_a.lit_cnt = cnt_v;
            end
            nc = ((kind_v == KIND_ZERO) ? cnt_v : 6'd0) + 6'd1;
            if (nc == RUN_MAX || final_byte) begin
                b_v        = 1'b1;
                cmd_b.ctrl = ZERO_FLAG | {2'b00, nc};
                kind_next  = KIND_IDLE;
                count_next = '0;
                held_next  = '0;
            end else begin
                kind_next  = KIND_ZERO;
                count_next = nc;
                held_next  = '0;
            end
        end else begin
            if (kind_v == KIND_ZERO) begin
                // short zero run is held in front of the literals
                if (cnt_v < SHORT_ZERO) begin
                    h = cnt_v[2:0];
                end else begin
                    a_v        = 1'b1;
                    cmd_a.ctrl = ZERO_FLAG | {2'b00, cnt_v};
                    h          = '0;
                end
                c = '0;
            end else if (kind_v == KIND_IDLE) begin
                h = '0;
                c = '0;
            end
            lit_we = acc;
            nc     = c + 6'd1;
            lim    = (h != 3'd0) ? MERGED_MAX : RUN_MAX;
            if (nc >= lim || final_byte) begin
                b_v           = 1'b1;
                cmd_b.ctrl    = lit_ctrl(h, nc);
                cmd_b.lit_cnt = nc;
                kind_next     = KIND_IDLE;
                count_next    = '0;
                held_next     = '0;
            end else begin
                kind_next  = KIND_LIT;
                count_next = nc;
                held_next  = h;
            end
        end

        if (b_v) begin
            cmd_b.last    = 1'b1;
            cmd_b.blk_end = final_byte;
        end else begin
            cmd_a.last = a_v;
        end
    end

    always_comb begin
        push = '0;
        if (acc) begin
            push.n = {1'b0, a_v} + {1'b0, b_v};
            if (a_v) begin
                push.first  = cmd_a;
                push.second = cmd_b;
            end else begin
                push.first = cmd_b;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg  <= KIND_IDLE;
            count_reg <= '0;
            held_reg  <= '0;
        end else if (acc) begin
            kind_reg  <= kind_next;
            count_reg <= count_next;
            held_reg  <= held_next;
        end
    end

endmodule

>>> design/zrle_back.sv
`timescale 1ns / 1ps
module zrle_back
    import zrle_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cmd_valid,
    input  cmd_t       cmd,
    output logic       cmd_pop,
    output logic       lit_re,
    input  logic [7:0] lit_rdata,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_item
);

    localparam logic ST_CTRL = 1'b0;
    localparam logic ST_LIT  = 1'b1;

    logic       state_reg, state_next;
    logic [5:0] rem_reg, rem_next;
    logic       last_reg, last_next;
    logic       end_reg, end_next;

    // read stage: literal data arrives in the cycle after the read
    logic       p1_valid_reg;
    out_item_t  p1_item_reg;
    logic       p1_lit_reg;
    out_item_t  p1_out;

    out_item_t          oq_reg [OUTQ_DEPTH];
    logic [OUTQ_AW-1:0] ow_ptr_reg, ow_ptr_next;
    logic [OUTQ_AW-1:0] or_ptr_reg, or_ptr_next;
    logic [OUTQ_AW:0]   ocnt_reg, ocnt_next;
    logic [OUTQ_AW:0]   occ_sum;

    logic       issue_ok;
    logic       iss;
    logic       iss_lit;
    out_item_t  iss_item;
    logic       o_pop;

    // count in-flight item so the output queue never overflows
    assign occ_sum  = ocnt_reg + (OUTQ_AW + 1)'(p1_valid_reg);
    assign issue_ok = (occ_sum < OUTQ_SLOTS);

    always_comb begin
        iss        = 1'b0;
        iss_lit    = 1'b0;
        iss_item   = '0;
        cmd_pop    = 1'b0;
        lit_re     = 1'b0;
        state_next = state_reg;
        rem_next   = rem_reg;
        last_next  = last_reg;
        end_next   = end_reg;

        unique case (state_reg)
            ST_CTRL: begin
                if (cmd_valid && issue_ok) begin
                    iss              = 1'b1;
                    cmd_pop          = 1'b1;
                    iss_item.code    = cmd.ctrl;
                    iss_item.is_ctrl = 1'b1;
                    iss_item.last    = cmd.last && (cmd.lit_cnt == 6'd0);
                    iss_item.blk_end = cmd.blk_end && (cmd.lit_cnt == 6'd0);
                    if (cmd.lit_cnt != 6'd0) begin
                        state_next = ST_LIT;
                        rem_next   = cmd.lit_cnt;
                        last_next  = cmd.last;
                        end_next   = cmd.blk_end;
                    end
                end
            end
            ST_LIT: begin
                if (issue_ok) begin
                    iss              = 1'b1;
                    iss_lit          = 1'b1;
                    lit_re           = 1'b1;
                    iss_item.last    = last_reg && (rem_reg == 6'd1);
                    iss_item.blk_end = end_reg && (rem_reg == 6'd1);
                    rem_next         = rem_reg - 6'd1;
                    if (rem_reg == 6'd1) begin
                        state_next = ST_CTRL;
                    end
                end
            end
            default: begin
                state_next = ST_CTRL;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CTRL;
            rem_reg      <= '0;
            last_reg     <= 1'b0;
            end_reg      <= 1'b0;
            p1_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rem_reg      <= rem_next;
            last_reg     <= last_next;
            end_reg      <= end_next;
            p1_valid_reg <= iss;
        end
    end

    always_ff @(posedge aclk) begin
        p1_item_reg <= iss_item;
        p1_lit_reg  <= iss_lit;
    end

    always_comb begin
        p1_out = p1_item_reg;
        if (p1_lit_reg) begin
            p1_out.code = lit_rdata;
        end
    end

    assign out_valid = (ocnt_reg != '0);
    assign out_item  = oq_reg[or_ptr_reg];
    assign o_pop     = out_valid && out_ready;

    always_comb begin
        ow_ptr_next = ow_ptr_reg + OUTQ_AW'(p1_valid_reg);
        or_ptr_next = or_ptr_reg + OUTQ_AW'(o_pop);
        ocnt_next   = ocnt_reg + (OUTQ_AW + 1)'(p1_valid_reg) - (OUTQ_AW + 1)'(o_pop);
    end

    always_ff @(posedge aclk) begin
        if (p1_valid_reg) begin
            oq_reg[ow_ptr_reg] <= p1_out;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ow_ptr_reg <= '0;
            or_ptr_reg <= '0;
            ocnt_reg   <= '0;
        end else begin
            ow_ptr_reg <= ow_ptr_next;
            or_ptr_reg <= or_ptr_next;
            ocnt_reg   <= ocnt_next;
        end
    end

endmodule

>>> design/zero_run_length_encoder.sv
`timescale 1ns / 1ps
// Zero run-length encoder: raw bytes in, compressed bytes out.
// Input channel (s_): one source byte per request, s_tlast marks the last
//   byte of a block. A request is taken when s_tvalid and s_tready are high.
// Output channel (m_): one compressed byte per request. m_tuser is set on
//   control bytes, m_tdata[8] on the last byte caused by one input, and
//   m_tlast on the last byte of the block.
// Front end classifies each byte, stores literals in a 64-byte buffer and
//   queues one command per closed run; the back end expands commands into
//   a control byte plus literals read back from the buffer.
// Path: the command that closes a run goes through the command queue, the read
//   stage register and the output queue before its first byte shows on m_.
// Throughput: one input per cycle and one output byte per cycle while m_tready
//   is high, set by the single read port of the literal buffer. s_tready drops while
//   the command queue has fewer than two free slots or the literal buffer is full.
// Receiver stall: a four-entry output queue absorbs the read pipeline; when
//   it fills the back end stops, the command queue fills, then s_tready falls.
// Reset: synchronous, active low; all queues empty, no run open.
module zero_run_length_encoder
    import zrle_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // final_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] code_byte, [8] group_last, [15:9] zero
    output logic        m_tuser,   // [0] is_control
    output logic        m_tlast    // block_end
);

    logic       lit_we;
    logic [7:0] lit_wdata;
    logic       lit_re;
    logic [7:0] lit_rdata;
    logic       lit_room;

    cmd_push_t  push;
    logic       cmdq_room2;
    logic       cmd_valid;
    cmd_t       cmd_head;
    logic       cmd_pop;

    out_item_t  out_item;

    zrle_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .data_byte  (s_tdata),
        .final_byte (s_tlast),
        .cmdq_room2 (cmdq_room2),
        .lit_room   (lit_room),
        .lit_we     (lit_we),
        .lit_wdata  (lit_wdata),
        .push       (push)
    );

    zrle_lit_buf u_lit_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (lit_we),
        .wr_data  (lit_wdata),
        .rd_en    (lit_re),
        .rd_data  (lit_rdata),
        .has_room (lit_room)
    );

    zrle_cmdq u_cmdq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .room2      (cmdq_room2),
        .head_valid (cmd_valid),
        .head       (cmd_head),
        .pop        (cmd_pop)
    );

    zrle_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd       (cmd_head),
        .cmd_pop   (cmd_pop),
        .lit_re    (lit_re),
        .lit_rdata (lit_rdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item)
    );

    assign m_tdata = {7'b0000000, out_item.last, out_item.code};
    assign m_tuser = out_item.is_ctrl;
    assign m_tlast = out_item.blk_end;

endmodule

>>> design/zrle_checker.sv
`timescale 1ns / 1ps
module zrle_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // nothing comes out right after reset
    a_quiet_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    // block end is always the last byte of its input's group
    a_end_is_group_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[8])
        else $error("block end without group last");

    // literals are nonzero and every control byte carries a count
    a_nonzero_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[7:0] != 8'd0)
        else $error("zero code byte on output");

    // stalled output request holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("output changed while stalled");

endmodule

bind zero_run_length_encoder zrle_checker u_zrle_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

>>> verif/tb_zero_run_length_encoder.sv
`timescale 1ns / 1ps
module tb_zero_run_length_encoder;
    import zrle_pkg::*;

    localparam int QUIET_LIMIT = 3000;   // cycles with no request on either side
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_AT = 100;        // results seen before the long sink hold-off
    localparam int HOLD_LEN = 400;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    zero_run_length_encoder DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // one source byte waiting to be sent, with the idle gap before it
    typedef struct {
        logic [7:0]  data;
        logic        fin;
        int unsigned gap;
    } src_byte_t;

    // one expected compressed byte
    typedef struct packed {
        logic [7:0] code;
        logic       is_ctrl;
        logic       group_last;
        logic       block_end;
    } code_rec_t;

    src_byte_t src_q[$];
    code_rec_t exp_codes[$];
    code_rec_t step_codes[$];

    // encoder state mirror
    logic [1:0] enc_kind;
    logic [5:0] enc_count;
    logic [2:0] enc_held;
    logic [7:0] enc_lits [0:62];

    int unsigned err_count = 0;
    int unsigned quiet = 0;
    int unsigned sink_seen = 0;
    int unsigned src_gap = 0;
    int unsigned sink_wait = 0;
    int unsigned sink_hold = 0;
    bit          src_burst = 1'b0;
    bit          sink_burst = 1'b0;
    bit          src_taken = 1'b0;
    bit          sink_taken = 1'b0;
    bit          hold_done = 1'b0;

    // ---------------- prediction ----------------

    task automatic emit_code(input logic [7:0] code, input logic ctrl);
        code_rec_t r;
        r.code       = code;
        r.is_ctrl    = ctrl;
        r.group_last = 1'b0;
        r.block_end  = 1'b0;
        step_codes.push_back(r);
    endtask

    // close whatever run is open: control byte, then its literals
    task automatic flush_run();
        int k;
        if (enc_kind == KIND_ZERO) begin
            emit_code(ZERO_FLAG | {2'b00, enc_count}, 1'b1);
        end else if (enc_kind == KIND_LIT) begin
            if (enc_held != 3'd0) begin
                emit_code(MERGED_FLAG | {1'b0, enc_held, enc_count[3:0]}, 1'b1);
            end else begin
                emit_code({2'b00, enc_count}, 1'b1);
            end
            for (k = 0; k < int'(enc_count) && k < 63; k++) begin
                emit_code(enc_lits[k], 1'b0);
            end
        end
        enc_kind  = KIND_IDLE;
        enc_count = '0;
        enc_held  = '0;
    endtask

    task automatic encode_byte(input logic [7:0] b, input logic fin);
        code_rec_t r;
        step_codes.delete();
        // any kind other than zero/literal counts as idle
        if (enc_kind != KIND_ZERO && enc_kind != KIND_LIT) begin
            enc_kind  = KIND_IDLE;
            enc_count = '0;
            enc_held  = '0;
        end
        if (b == 8'h00) begin
            if (enc_kind == KIND_LIT) flush_run();
            if (enc_kind != KIND_ZERO) begin
                enc_kind  = KIND_ZERO;
                enc_count = '0;
                enc_held  = '0;
            end
            enc_count++;
            if (enc_count >= RUN_MAX) flush_run();
        end else begin
            if (enc_kind == KIND_ZERO) begin
                // short zero run is held in front of the literals
                if (enc_count < SHORT_ZERO) begin
                    enc_held = enc_count[2:0];
                end else begin
                    flush_run();
                    enc_held = '0;
                end
                enc_kind  = KIND_LIT;
                enc_count = '0;
            end else if (enc_kind == KIND_IDLE) begin
                enc_kind  = KIND_LIT;
                enc_count = '0;
                enc_held  = '0;
            end
            if (enc_count < RUN_MAX) begin
                enc_lits[enc_count] = b;
                enc_count++;
            end
            if (enc_count >= ((enc_held != 3'd0) ? MERGED_MAX : RUN_MAX)) flush_run();
        end
        if (fin) flush_run();
        if (step_codes.size() > 0) begin
            r = step_codes.pop_back();
            r.group_last = 1'b1;
            r.block_end  = fin;
            step_codes.push_back(r);
        end
        foreach (step_codes[i]) exp_codes.push_back(step_codes[i]);
    endtask

    // ---------------- stimulus ----------------

    task automatic add_byte(input logic [7:0] b, input logic fin);
        src_byte_t it;
        if ($urandom_range(0, 39) == 0) src_burst = !src_burst;
        it.data = b;
        it.fin  = fin;
        it.gap  = src_burst ? 0 : $urandom_range(0, 8);
        src_q.push_back(it);
    endtask

    task automatic add_run(input bit zeros, input int len, input logic fin_at_end);
        int i;
        for (i = 0; i < len; i++) begin
            add_byte(zeros ? 8'h00 : 8'($urandom_range(1, 255)), fin_at_end && (i == len - 1));
        end
    endtask

    // driver: presents the head of src_q, pops it once the request is taken
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (src_taken) begin
                src_taken = 1'b0;
                void'(src_q.pop_front());
                if (src_q.size() != 0) src_gap = src_q[0].gap;
            end
            if (src_gap != 0) begin
                src_gap--;
                s_tvalid <= 1'b0;
            end else if (src_q.size() != 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= src_q[0].data;
                s_tlast  <= src_q[0].fin;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // sink: random ready gaps, plus one long hold-off so the encoder backs up
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (sink_taken) begin
                sink_taken = 1'b0;
                if (!hold_done && sink_seen >= HOLD_AT) begin
                    hold_done = 1'b1;
                    sink_hold = HOLD_LEN;
                end
                if ($urandom_range(0, 31) == 0) sink_burst = !sink_burst;
                sink_wait = sink_burst ? 0 : $urandom_range(0, 8);
            end
            if (sink_hold != 0) begin
                sink_hold--;
                m_tready <= 1'b0;
            end else if (sink_wait != 0) begin
                sink_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // monitor: predicts on every input request, checks every output request
    always @(posedge aclk) begin
        code_rec_t e;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                encode_byte(s_tdata, s_tlast);
                src_taken = 1'b1;
            end
            if (m_tvalid && m_tready) begin
                sink_taken = 1'b1;
                sink_seen++;
                if (exp_codes.size() == 0) begin
                    $error("unexpected output byte %h", m_tdata[7:0]);
                    err_count++;
                end else begin
                    e = exp_codes.pop_front();
                    if (m_tdata[7:0] !== e.code) begin
                        $error("code_byte: expected %h, actual %h", e.code, m_tdata[7:0]);
                        err_count++;
                    end
                    if (m_tuser !== e.is_ctrl) begin
                        $error("is_control: expected %b, actual %b", e.is_ctrl, m_tuser);
                        err_count++;
                    end
                    if (m_tdata[8] !== e.group_last) begin
                        $error("group_last: expected %b, actual %b", e.group_last, m_tdata[8]);
                        err_count++;
                    end
                    if (m_tlast !== e.block_end) begin
                        $error("block_end: expected %b, actual %b", e.block_end, m_tlast);
                        err_count++;
                    end
                    if (m_tdata[15:9] !== 7'd0) begin
                        $error("tdata pad: expected %h, actual %h", 7'd0, m_tdata[15:9]);
                        err_count++;
                    end
                end
            end
            // watchdog
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
                if (quiet >= QUIET_LIMIT) begin
                    $display("DONE: errors detected");
                    $finish;
                end
            end
        end
    end

    initial begin
        int  n;
        int  n_runs;
        int  len;
        int  r;
        int  i;
        bit  zeros;

        enc_kind  = KIND_IDLE;
        enc_count = '0;
        enc_held  = '0;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'h00;
        s_tlast   = 1'b0;
        m_tready  = 1'b0;

        // directed: lone zero at end, lone literals, merged run,
        // long zero run before a literal, short zero run at end,
        // literal run closed by a trailing zero
        add_byte(8'h00, 1'b1);
        add_byte(8'hff, 1'b1);
        add_byte(8'h01, 1'b0);
        add_byte(8'h80, 1'b1);
        add_run(1'b1, 3, 1'b0);
        add_byte(8'h55, 1'b0);
        add_byte(8'haa, 1'b1);
        add_run(1'b1, 8, 1'b0);
        add_byte(8'h7f, 1'b1);
        add_run(1'b1, 3, 1'b1);
        add_byte(8'hff, 1'b0);
        add_byte(8'h00, 1'b1);

        // random: mostly well-formed blocks of alternating runs, some noise
        while (src_q.size() < 400) begin
            if ($urandom_range(0, 5) == 0) begin
                n = $urandom_range(4, 20);
                for (i = 0; i < n; i++) begin
                    add_byte(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255)),
                             $urandom_range(0, 15) == 0);
                end
            end else begin
                n_runs = $urandom_range(1, 6);
                zeros  = 1'($urandom_range(0, 1));
                for (r = 0; r < n_runs && src_q.size() < 400; r++) begin
                    case ($urandom_range(0, 9)) inside
                        [0:3]:   len = $urandom_range(1, 7);
                        [4:5]:   len = $urandom_range(8, 20);
                        6:       len = $urandom_range(21, 62);
                        7:       len = 63;
                        8:       len = $urandom_range(14, 16);
                        default: len = $urandom_range(64, 70);
                    endcase
                    add_run(zeros, len, r == n_runs - 1);
                    zeros = !zeros;
                end
            end
        end
        add_byte(8'($urandom_range(0, 255)), 1'b1);

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        wait (src_q.size() == 0);
        wait (exp_codes.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (exp_codes.size() != 0) begin
            $error("%0d expected bytes never arrived", exp_codes.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> files.f
design/zrle_pkg.sv
design/zrle_lit_buf.sv
design/zrle_cmdq.sv
design/zrle_front.sv
design/zrle_back.sv
design/zero_run_length_encoder.sv
design/zrle_checker.sv
verif/tb_zero_run_length_encoder.sv
